FILE: rtl/core/utf8_byte_stream_decoder_assert.svh
// ---------------------------------------------------------------------------
// UTF-8 decoder assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef UTF8_BYTE_STREAM_DECODER_ASSERT_SVH
`define UTF8_BYTE_STREAM_DECODER_ASSERT_SVH

// same-cycle implication
`define U8D_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("u8d: same-cycle check failed");

// next-cycle implication
`define U8D_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("u8d: next-cycle check failed");

`endif

FILE: rtl/core/u8d_pkg.sv
// ---------------------------------------------------------------------------
// u8d_pkg
// Types and constants shared by the UTF-8 byte stream decoder.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package u8d_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned CP_W   = 21;
	localparam int unsigned ST_W   = 2;
	localparam int unsigned CNT_W  = 3;
	localparam int unsigned BITS_W = 7;
	localparam int unsigned CONT_W = 6;
	localparam int unsigned PART_W = CP_W - CONT_W;
	localparam int unsigned PEND_W = 2;

	localparam int unsigned QDEPTH = 2;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [ST_W-1:0] ST_OK        = 2'd0;
	localparam logic [ST_W-1:0] ST_INVALID   = 2'd1;
	localparam logic [ST_W-1:0] ST_TRUNCATED = 2'd2;

	localparam logic [CNT_W-1:0] LEN_ONE   = 3'd1;
	localparam logic [CNT_W-1:0] LEN_TWO   = 3'd2;
	localparam logic [CNT_W-1:0] LEN_THREE = 3'd3;
	localparam logic [CNT_W-1:0] LEN_FOUR  = 3'd4;

	typedef enum logic [2:0] {
		KIND_ASCII,
		KIND_CONT,
		KIND_LEAD2,
		KIND_LEAD3,
		KIND_LEAD4,
		KIND_BAD
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		logic [BITS_W-1:0] bits;
		logic              eos;
	} item_t;

endpackage

FILE: rtl/core/u8d_stream_if.sv
// ---------------------------------------------------------------------------
// u8d stream interfaces
// Valid/ready channels for input bytes and decoded code points.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface u8d_byte_if;
	logic                          valid;
	logic                          ready;
	logic [u8d_pkg::BYTE_W-1:0]    data_byte;
	logic                          end_of_stream;

	modport source (output valid, output data_byte, output end_of_stream, input ready);
	modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface u8d_cp_if;
	logic                          valid;
	logic                          ready;
	logic [u8d_pkg::CP_W-1:0]      code_point;
	logic [u8d_pkg::ST_W-1:0]      status;
	logic [u8d_pkg::CNT_W-1:0]     byte_count;

	modport source (output valid, output code_point, output status, output byte_count,
		input ready);
	modport sink   (input valid, input code_point, input status, input byte_count,
		output ready);
endinterface

FILE: rtl/core/u8d_front.sv
// ---------------------------------------------------------------------------
// u8d_front
// Accepts bytes, classifies each one and pushes it into the queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module u8d_front (
	u8d_byte_if.sink         in_byte,
	input  logic             q_full,
	output logic             push,
	output u8d_pkg::item_t   item
);

	logic [u8d_pkg::BYTE_W-1:0] b;

	assign b             = in_byte.data_byte;
	assign in_byte.ready = !q_full;
	assign push          = in_byte.valid && !q_full;

	always_comb begin
		item.eos = in_byte.end_of_stream;
		unique casez (b[7:3])
			5'b0????: begin
				item.kind = u8d_pkg::KIND_ASCII;
				item.bits = b[6:0];
			end
			5'b10???: begin
				item.kind = u8d_pkg::KIND_CONT;
				item.bits = {1'b0, b[5:0]};
			end
			5'b110??: begin
				item.kind = u8d_pkg::KIND_LEAD2;
				item.bits = {2'b0, b[4:0]};
			end
			5'b1110?: begin
				item.kind = u8d_pkg::KIND_LEAD3;
				item.bits = {3'b0, b[3:0]};
			end
			5'b11110: begin
				item.kind = u8d_pkg::KIND_LEAD4;
				item.bits = {4'b0, b[2:0]};
			end
			default: begin
				item.kind = u8d_pkg::KIND_BAD;
				item.bits = '0;
			end
		endcase
	end

endmodule

FILE: rtl/core/u8d_queue.sv
// ---------------------------------------------------------------------------
// u8d_queue
// Small FIFO of classified bytes between front and back.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module u8d_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  u8d_pkg::item_t   wr_item,
	input  logic             pop,
	output logic             full,
	output logic             valid,
	output u8d_pkg::item_t   rd_item
);

	u8d_pkg::item_t                  mem_q [u8d_pkg::QDEPTH];
	logic [u8d_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [u8d_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [u8d_pkg::QCNT_W-1:0]      cnt_q;

	function automatic logic [u8d_pkg::QPTR_W-1:0] ptr_next(
		input logic [u8d_pkg::QPTR_W-1:0] p
	);
		ptr_next = (p == u8d_pkg::QPTR_W'(u8d_pkg::QDEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full    = (cnt_q == u8d_pkg::QCNT_W'(u8d_pkg::QDEPTH));
	assign valid   = (cnt_q != '0);
	assign rd_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= ptr_next(wr_ptr_q);
			if (pop)
				rd_ptr_q <= ptr_next(rd_ptr_q);
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_item;
	end

endmodule

FILE: rtl/core/u8d_back.sv
// ---------------------------------------------------------------------------
// u8d_back
// Sequence tracker: assembles code points and drives the result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module u8d_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  u8d_pkg::item_t   q_item,
	output logic             pop,
	u8d_cp_if.source         out_cp
);

	logic [u8d_pkg::PEND_W-1:0] pend_q, pend_d;
	logic [u8d_pkg::PART_W-1:0] part_q, part_d;
	logic [u8d_pkg::CNT_W-1:0]  len_q, len_d;

	logic                       out_valid_q;
	logic [u8d_pkg::CP_W-1:0]   cp_q;
	logic [u8d_pkg::ST_W-1:0]   st_q;
	logic [u8d_pkg::CNT_W-1:0]  cnt_q;

	logic                       emit;
	logic [u8d_pkg::CP_W-1:0]   e_cp;
	logic [u8d_pkg::ST_W-1:0]   e_st;
	logic [u8d_pkg::CNT_W-1:0]  e_cnt;
	logic [u8d_pkg::CP_W-1:0]   joined;

	assign pop               = q_valid && (!out_valid_q || out_cp.ready);
	assign out_cp.valid      = out_valid_q;
	assign out_cp.code_point = cp_q;
	assign out_cp.status     = st_q;
	assign out_cp.byte_count = cnt_q;

	assign joined = {part_q, q_item.bits[u8d_pkg::CONT_W-1:0]};

	always_comb begin
		emit   = 1'b0;
		e_cp   = '0;
		e_st   = u8d_pkg::ST_OK;
		e_cnt  = '0;
		pend_d = pend_q;
		part_d = part_q;
		len_d  = len_q;
		if (pend_q == '0) begin
			unique case (q_item.kind) inside
				u8d_pkg::KIND_ASCII: begin
					emit  = 1'b1;
					e_cp  = u8d_pkg::CP_W'(q_item.bits);
					e_cnt = u8d_pkg::LEN_ONE;
				end
				u8d_pkg::KIND_CONT, u8d_pkg::KIND_BAD: begin
					emit  = 1'b1;
					e_st  = u8d_pkg::ST_INVALID;
					e_cnt = u8d_pkg::LEN_ONE;
				end
				u8d_pkg::KIND_LEAD2: begin
					part_d = u8d_pkg::PART_W'(q_item.bits[4:0]);
					pend_d = 2'd1;
					len_d  = u8d_pkg::LEN_TWO;
				end
				u8d_pkg::KIND_LEAD3: begin
					part_d = u8d_pkg::PART_W'(q_item.bits[3:0]);
					pend_d = 2'd2;
					len_d  = u8d_pkg::LEN_THREE;
				end
				u8d_pkg::KIND_LEAD4: begin
					part_d = u8d_pkg::PART_W'(q_item.bits[2:0]);
					pend_d = 2'd3;
					len_d  = u8d_pkg::LEN_FOUR;
				end
				default: begin
					emit  = 1'b1;
					e_st  = u8d_pkg::ST_INVALID;
					e_cnt = u8d_pkg::LEN_ONE;
				end
			endcase
			if (pend_d != '0 && q_item.eos) begin
				emit   = 1'b1;
				e_st   = u8d_pkg::ST_TRUNCATED;
				pend_d = '0;
			end
		end else if (q_item.kind != u8d_pkg::KIND_CONT) begin
			emit   = 1'b1;
			e_st   = u8d_pkg::ST_INVALID;
			e_cnt  = len_q - u8d_pkg::CNT_W'(pend_q) + u8d_pkg::LEN_ONE;
			pend_d = '0;
		end else begin
			pend_d = pend_q - 1'b1;
			part_d = joined[u8d_pkg::PART_W-1:0];
			if (pend_d == '0) begin
				emit  = 1'b1;
				e_cp  = joined;
				e_cnt = len_q;
			end else if (q_item.eos) begin
				emit   = 1'b1;
				e_st   = u8d_pkg::ST_TRUNCATED;
				pend_d = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				pend_q      <= pend_d;
				out_valid_q <= emit;
			end else if (out_cp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			part_q <= part_d;
			len_q  <= len_d;
		end
		if (pop && emit) begin
			cp_q  <= e_cp;
			st_q  <= e_st;
			cnt_q <= e_cnt;
		end
	end

endmodule

FILE: rtl/core/utf8_byte_stream_decoder.sv
// ---------------------------------------------------------------------------
// utf8_byte_stream_decoder
// UTF-8 byte stream to code point decoder with classify front, item queue
// and sequence-tracking back end.
//
//   channel   dir  payload                             item
//   in_byte   in   data_byte[7:0], end_of_stream       one raw byte
//   out_cp    out  code_point[20:0], status[1:0],      one result
//                  byte_count[2:0]
//
// One byte per cycle sustained while out_cp.ready holds; a result is valid
// once its final byte has passed the queue and then the result register.
// Throughput is set by the sequence tracker in the back end.
// Reset clears queue pointers, pending count and result valid; no clear pass.
// A stalled output holds the back end; the two-entry queue then fills and
// in_byte.ready drops until the cycle after the back end pops again.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "utf8_byte_stream_decoder_assert.svh"

module utf8_byte_stream_decoder (
	input  logic       clk,
	input  logic       arst_n,
	u8d_byte_if.sink   in_byte,
	u8d_cp_if.source   out_cp
);

	logic             push;
	logic             pop;
	logic             q_full;
	logic             q_valid;
	u8d_pkg::item_t   wr_item;
	u8d_pkg::item_t   rd_item;

	u8d_front u_front (
		.in_byte (in_byte),
		.q_full  (q_full),
		.push    (push),
		.item    (wr_item)
	);

	u8d_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_item (wr_item),
		.pop     (pop),
		.full    (q_full),
		.valid   (q_valid),
		.rd_item (rd_item)
	);

	u8d_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_item  (rd_item),
		.pop     (pop),
		.out_cp  (out_cp)
	);

	`U8D_ASSERT_NOW(a_bad_cp_zero, clk, arst_n,
		out_cp.valid && out_cp.status != u8d_pkg::ST_OK, out_cp.code_point == '0)
	`U8D_ASSERT_NOW(a_trunc_cnt_zero, clk, arst_n,
		out_cp.valid && out_cp.status == u8d_pkg::ST_TRUNCATED, out_cp.byte_count == '0)
	`U8D_ASSERT_NOW(a_ok_cnt_nonzero, clk, arst_n,
		out_cp.valid && out_cp.status == u8d_pkg::ST_OK, out_cp.byte_count != '0)
	`U8D_ASSERT_NOW(a_stall_means_backlog, clk, arst_n, !in_byte.ready, q_valid)
	`U8D_ASSERT_NEXT(a_pop_had_data, clk, arst_n, push && !q_valid, q_valid)

endmodule

FILE: tb/sv/utf8_byte_stream_decoder_tb.sv
// ---------------------------------------------------------------------------
// utf8_byte_stream_decoder_tb
// Self-checking bench for the UTF-8 byte stream decoder. Bytes come from
// a queue through a valid/ready driver. A scoreboard decodes each accepted
// byte and queues the code point it should produce. The monitor checks
// every result against the oldest queued one. Directed corner cases come
// first, then mostly well-formed random sequences mixed with noise and
// broken sequences, under several sender/receiver idle mixes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf8_byte_stream_decoder_tb;
	import u8d_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned DRAIN_CYCLES = 10;
	localparam int unsigned RAND_PER_PHASE = 200;

	typedef struct {
		logic [BYTE_W-1:0] data_byte;
		logic              end_of_stream;
	} byte_item_t;

	typedef struct {
		logic [CP_W-1:0]  code_point;
		logic [ST_W-1:0]  status;
		logic [CNT_W-1:0] byte_count;
	} cp_result_t;

	logic clk;
	logic arst_n;

	u8d_byte_if bi ();
	u8d_cp_if   co ();

	utf8_byte_stream_decoder u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_byte(bi),
		.out_cp (co)
	);

	byte_item_t  byte_q[$];
	cp_result_t  cp_exp_q[$];
	int unsigned send_idle_pct;
	int unsigned stall_pct;
	int unsigned err_cnt;
	int unsigned cyc_cnt;

	// decoder shadow state
	logic [PEND_W-1:0] dec_pend;
	logic [CP_W-1:0]   dec_part;
	logic [CNT_W-1:0]  dec_len;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) cyc_cnt <= cyc_cnt + 1;

	task automatic report(input string what, input int unsigned got, input int unsigned want);
		$display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cyc_cnt);
		err_cnt++;
	endtask

	function automatic bit decode_byte(input logic [BYTE_W-1:0] b, input logic eos,
		output cp_result_t r);
		bit has;
		has = 1'b0;
		r.code_point = '0;
		r.status = ST_OK;
		r.byte_count = '0;
		if (dec_pend == '0) begin
			if (b <= 8'h7F) begin
				r.code_point = CP_W'(b);
				r.byte_count = LEN_ONE;
				has = 1'b1;
			end else if (b < 8'hC0 || b >= 8'hF8) begin
				r.status = ST_INVALID;
				r.byte_count = LEN_ONE;
				has = 1'b1;
			end else begin
				if (b < 8'hE0) begin
					dec_part = CP_W'(b & 8'h1F);
					dec_pend = 2'd1;
					dec_len = LEN_TWO;
				end else if (b < 8'hF0) begin
					dec_part = CP_W'(b & 8'h0F);
					dec_pend = 2'd2;
					dec_len = LEN_THREE;
				end else begin
					dec_part = CP_W'(b & 8'h07);
					dec_pend = 2'd3;
					dec_len = LEN_FOUR;
				end
				if (eos) begin
					r.status = ST_TRUNCATED;
					has = 1'b1;
				end
			end
		end else if (b < 8'h80 || b >= 8'hC0) begin
			r.status = ST_INVALID;
			r.byte_count = CNT_W'(dec_len - {1'b0, dec_pend} + 3'd1);
			has = 1'b1;
		end else begin
			dec_part = CP_W'({dec_part, b[5:0]});
			dec_pend = dec_pend - 2'd1;
			if (dec_pend == '0) begin
				r.code_point = dec_part;
				r.byte_count = dec_len;
				has = 1'b1;
			end else if (eos) begin
				r.status = ST_TRUNCATED;
				has = 1'b1;
			end
		end
		if (has) begin
			dec_pend = '0;
			dec_part = '0;
			dec_len = '0;
		end
		return has;
	endfunction

	// driver
	always @(posedge clk) begin
		byte_item_t it;
		cp_result_t r;
		if (!arst_n) begin
			bi.valid <= 1'b0;
		end else begin
			if (bi.valid && bi.ready) begin
				if (decode_byte(bi.data_byte, bi.end_of_stream, r))
					cp_exp_q = {cp_exp_q, r};
			end
			if (!bi.valid || bi.ready) begin
				if (byte_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					it = byte_q.pop_front();
					bi.valid <= 1'b1;
					bi.data_byte <= it.data_byte;
					bi.end_of_stream <= it.end_of_stream;
				end else begin
					bi.valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		cp_result_t e;
		if (!arst_n) begin
			co.ready <= 1'b0;
		end else begin
			if (co.valid && co.ready) begin
				if (cp_exp_q.size() == 0) begin
					report("unexpected result, code_point", co.code_point, 0);
				end else begin
					e = cp_exp_q.pop_front();
					if (co.code_point !== e.code_point)
						report("code_point", co.code_point, e.code_point);
					if (co.status !== e.status)
						report("status", co.status, e.status);
					if (co.byte_count !== e.byte_count)
						report("byte_count", co.byte_count, e.byte_count);
				end
			end
			co.ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	function automatic void add_byte(input logic [BYTE_W-1:0] b, input logic eos);
		byte_item_t it;
		it.data_byte = b;
		it.end_of_stream = eos;
		byte_q = {byte_q, it};
	endfunction

	function automatic logic [BYTE_W-1:0] lead_byte(input int unsigned len);
		logic [BYTE_W-1:0] v;
		v = BYTE_W'($urandom);
		case (len)
			1: v = {1'b0, v[6:0]};
			2: v = {3'b110, v[4:0]};
			3: v = {4'b1110, v[3:0]};
			default: v = {5'b11110, v[2:0]};
		endcase
		return v;
	endfunction

	function automatic logic [BYTE_W-1:0] cont_byte();
		logic [BYTE_W-1:0] v;
		v = BYTE_W'($urandom);
		return {2'b10, v[5:0]};
	endfunction

	function automatic logic rand_eos();
		return ($urandom_range(0, 99) < 4);
	endfunction

	// returns number of bytes queued
	function automatic int unsigned add_random_chunk();
		int unsigned pick;
		int unsigned len;
		int unsigned n;
		pick = $urandom_range(0, 99);
		len = $urandom_range(1, 4);
		n = 0;
		if (pick < 75) begin
			add_byte(lead_byte(len), rand_eos());
			for (n = 1; n < len; n++)
				add_byte(cont_byte(), rand_eos());
		end else if (pick < 88) begin
			add_byte(BYTE_W'($urandom_range(0, 255)), rand_eos());
			n = 1;
		end else begin
			len = $urandom_range(2, 4);
			add_byte(lead_byte(len), 1'b0);
			for (n = 1; n < $urandom_range(1, len - 1); n++)
				add_byte(cont_byte(), 1'b0);
			if ($urandom_range(0, 1))
				add_byte(BYTE_W'($urandom_range(0, 127)), rand_eos());
			else
				add_byte(BYTE_W'($urandom_range(192, 255)), rand_eos());
			n++;
		end
		return n;
	endfunction

	task automatic drain();
		while (byte_q.size() > 0 || bi.valid || cp_exp_q.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		wait (cyc_cnt >= CYCLE_LIMIT);
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		int unsigned cnt;
		int unsigned ph;
		cyc_cnt = 0;
		err_cnt = 0;
		dec_pend = '0;
		dec_part = '0;
		dec_len = '0;
		send_idle_pct = 0;
		stall_pct = 0;
		arst_n = 1'b0;
		bi.valid = 1'b0;
		bi.data_byte = '0;
		bi.end_of_stream = 1'b0;
		co.ready = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// one-byte extremes, stray continuation, bad leads
		add_byte(8'h00, 1'b0);
		add_byte(8'h7F, 1'b0);
		add_byte(8'h80, 1'b0);
		add_byte(8'hBF, 1'b0);
		add_byte(8'hF8, 1'b0);
		add_byte(8'hFF, 1'b0);
		// multi-byte extremes
		add_byte(8'hDF, 1'b0); add_byte(8'hBF, 1'b0);
		add_byte(8'hE0, 1'b0); add_byte(8'h80, 1'b0); add_byte(8'h80, 1'b0);
		add_byte(8'hF7, 1'b0); add_byte(8'hBF, 1'b0); add_byte(8'hBF, 1'b0);
		add_byte(8'hBF, 1'b0);
		// bad continuation: ascii, then lead byte
		add_byte(8'hC2, 1'b0); add_byte(8'h41, 1'b0);
		add_byte(8'hF0, 1'b0); add_byte(8'h90, 1'b0); add_byte(8'hC0, 1'b0);
		// end of stream after lead, mid-sequence, with invalid byte, on last byte
		add_byte(8'hC3, 1'b1);
		add_byte(8'hE2, 1'b0); add_byte(8'h82, 1'b1);
		add_byte(8'hE2, 1'b0); add_byte(8'hFF, 1'b1);
		add_byte(8'hC0, 1'b0); add_byte(8'h80, 1'b1);
		drain();

		for (ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0; stall_pct = 0; end
				1: begin send_idle_pct = 71; stall_pct = 0; end
				2: begin send_idle_pct = 0; stall_pct = 71; end
				default: begin send_idle_pct = 10; stall_pct = 10; end
			endcase
			cnt = 0;
			while (cnt < RAND_PER_PHASE)
				cnt += add_random_chunk();
			drain();
		end

		if (err_cnt == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/u8d_pkg.sv
rtl/core/u8d_stream_if.sv
rtl/core/u8d_front.sv
rtl/core/u8d_queue.sv
rtl/core/u8d_back.sv
rtl/core/utf8_byte_stream_decoder.sv
tb/sv/utf8_byte_stream_decoder_tb.sv
